// ===== rtl/tdt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared constants and controller/datapath interface types for the
// time-dependent tour time core.
// ----------------------------------------------------------------------------
package tdt_pkg;

  localparam int DEF_MAX_CITIES    = 64;
  localparam int DEF_MAX_INTERVALS = 8;
  localparam int DEF_MAX_CLUSTERS  = 4;

  localparam logic [23:0] MIN_SPEED = 24'd7;
  localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;
  localparam int          DIV_STEPS = 48;
  localparam int          CL_STEPS  = 8;

  localparam logic [2:0] REQ_DIST  = 3'd0;
  localparam logic [2:0] REQ_CLUS  = 3'd1;
  localparam logic [2:0] REQ_SPEED = 3'd2;
  localparam logic [2:0] REQ_INTV  = 3'd3;
  localparam logic [2:0] REQ_VISIT = 3'd4;

  typedef struct packed {
    logic cap_in;
    logic wr_dist;
    logic wr_clus;
    logic wr_speed;
    logic wr_intv;
    logic tour_start;
    logic leg_close;
    logic leg_ld;
    logic srch_inc;
    logic sp_ld;
    logic sp_min;
    logic div_start_leg;
    logic div_start_cl;
    logic div_step;
    logic cl_step;
    logic arr_ld;
    logic intv_sel_m;
    logic e_ld;
    logic m_inc;
    logic mul_ld;
    logic cov_ld;
    logic commit;
    logic prev_upd;
    logic res_ld;
  } tdt_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       last;
    logic       dist_ok;
    logic       speed_ok;
    logic       intv_ok;
    logic       row_ok;
    logic       tour_active;
    logic       srch_hit;
    logic       srch_end;
    logic       div_done;
    logic       cl_done;
    logic       arr_gt_end;
    logic       end_gt_t;
    logic       m_last;
    logic       out_busy;
  } tdt_sts_t;

endpackage

// ===== rtl/tdt_datapath.sv =====
// ----------------------------------------------------------------------------
// tdt_datapath
// Tables, leg registers, radix-2 divider, cluster remainder unit and
// coverage multiplier.
// ----------------------------------------------------------------------------
module tdt_datapath import tdt_pkg::*; #(
  parameter int MAX_CITIES    = DEF_MAX_CITIES,
  parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
  parameter int MAX_CLUSTERS  = DEF_MAX_CLUSTERS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tdt_cmd_t    cmd,
  output tdt_sts_t    sts,
  input  logic [2:0]  in_req_type,
  input  logic [5:0]  in_row_index,
  input  logic [5:0]  in_col_index,
  input  logic [31:0] in_load_value,
  input  logic [31:0] in_load_value_hi,
  input  logic        in_last_city,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_tour_time,
  output logic        out_saturated
);

  localparam int CW  = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int AW  = $clog2(MAX_CITIES * MAX_CITIES);
  localparam int IW  = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int NW  = $clog2(MAX_INTERVALS + 1);
  localparam int CLW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int SN  = MAX_INTERVALS * MAX_CLUSTERS;
  localparam int SW  = (SN > 1) ? $clog2(SN) : 1;

  logic [31:0] dist_mem [MAX_CITIES*MAX_CITIES];
  logic [CLW-1:0] clus_mem [MAX_CITIES*MAX_CITIES];
  logic [23:0] speed_mem [SN];
  logic [63:0] intv_mem [MAX_INTERVALS];

  logic [2:0]  req_r;
  logic [5:0]  row_r, col_r;
  logic [31:0] val_r, val_hi_r;
  logic        last_r;
  logic [3:0]  cfg_r;

  logic [CW-1:0]  first_r, prev_r;
  logic [31:0]    time_r;
  logic [IW-1:0]  pos_r;
  logic           active_r, sat_r;

  logic [31:0]    dist_q;
  logic [CLW-1:0] cl_q;
  logic [23:0]    sp_q;
  logic [63:0]    intv_q;

  logic [31:0]    dist_r, t_r, arr_r, e_r;
  logic [CLW-1:0] cl_r;
  logic [23:0]    sp_r;
  logic [IW-1:0]  i_r, m_r;
  logic [55:0]    prod_r;

  logic [47:0]    dvd_r;
  logic [23:0]    dsr_r, rem_r;
  logic [5:0]     cnt_r;

  logic [AW-1:0]  wr_idx, rd_idx;
  logic [CW-1:0]  to_city;
  logic [SW-1:0]  sp_wr_idx, sp_rd_idx;
  logic [IW-1:0]  intv_rd_idx;
  logic [NW-1:0]  n_used;
  logic [IW-1:0]  m_init;
  logic [24:0]    rem_sh;
  logic           rem_ge;
  logic [31:0]    q_clamp;
  logic           q_ovf;
  logic [32:0]    t_sum;
  logic [39:0]    cov;
  logic           out_valid_r;
  logic [31:0]    out_time_r;
  logic           out_sat_r;

  // reduce one nibble step of the cluster remainder, input below 16 * MAX_CLUSTERS
  function automatic logic [7:0] mod_step(input logic [7:0] x);
    logic [7:0] r;
    r = x;
    for (int j = 3; j >= 0; j--) begin
      if (int'(r) >= (MAX_CLUSTERS << j)) begin
        r = 8'(int'(r) - (MAX_CLUSTERS << j));
      end
    end
    return r;
  endfunction

  always_comb begin
    if (cfg_r == 4'd0) begin
      n_used = NW'(1);
    end else if (int'(cfg_r) > MAX_INTERVALS) begin
      n_used = NW'(MAX_INTERVALS);
    end else begin
      n_used = NW'(cfg_r);
    end
  end

  assign m_init = (int'(pos_r) + 1 >= int'(n_used)) ? IW'(int'(n_used) - 1) : pos_r;

  assign to_city   = cmd.leg_close ? first_r : CW'(row_r);
  assign rd_idx    = AW'(int'(prev_r) * MAX_CITIES + int'(to_city));
  assign wr_idx    = AW'(int'(row_r) * MAX_CITIES + int'(col_r));
  assign sp_wr_idx = SW'(int'(row_r) * MAX_CLUSTERS + int'(col_r));
  assign sp_rd_idx = SW'(int'(i_r) * MAX_CLUSTERS + int'(cl_r));
  assign intv_rd_idx = cmd.intv_sel_m ? m_r : i_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_dist) begin
      dist_mem[wr_idx] <= val_r;
    end
    if (cmd.wr_clus) begin
      clus_mem[wr_idx] <= rem_r[CLW-1:0];
    end
    if (cmd.wr_speed) begin
      speed_mem[sp_wr_idx] <= val_r[23:0];
    end
    if (cmd.wr_intv) begin
      intv_mem[IW'(row_r)] <= {val_hi_r, val_r};
    end
    dist_q <= dist_mem[rd_idx];
    cl_q   <= clus_mem[rd_idx];
    sp_q   <= speed_mem[sp_rd_idx];
    intv_q <= intv_mem[intv_rd_idx];
  end

  assign rem_sh  = {rem_r, dvd_r[47]};
  assign rem_ge  = rem_sh >= {1'b0, dsr_r};
  assign q_ovf   = |dvd_r[47:32];
  assign q_clamp = q_ovf ? TIME_MAX : dvd_r[31:0];
  assign t_sum   = {1'b0, t_r} + {1'b0, q_clamp};
  assign cov     = prod_r[55:16];

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      req_r    <= in_req_type;
      row_r    <= in_row_index;
      col_r    <= in_col_index;
      val_r    <= in_load_value;
      val_hi_r <= in_load_value_hi;
      last_r   <= in_last_city;
    end
    if (cmd.leg_ld) begin
      dist_r <= dist_q;
      cl_r   <= cl_q;
      t_r    <= time_r;
      m_r    <= m_init;
      i_r    <= '0;
    end else if (cmd.srch_inc) begin
      i_r <= i_r + IW'(1);
    end else if (cmd.cov_ld) begin
      i_r <= '0;
    end else if (cmd.e_ld && !(intv_q[63:32] > t_r)) begin
      i_r <= '0;
    end
    if (cmd.sp_ld) begin
      sp_r <= (sp_q == 24'd0) ? MIN_SPEED : sp_q;
    end else if (cmd.sp_min) begin
      sp_r <= MIN_SPEED;
    end
    if (cmd.div_start_leg) begin
      dvd_r <= {dist_r, 16'd0};
      dsr_r <= sp_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_start_cl) begin
      dvd_r <= {16'd0, val_r};
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? 24'(rem_sh - {1'b0, dsr_r}) : rem_sh[23:0];
      dvd_r <= {dvd_r[46:0], rem_ge};
      cnt_r <= cnt_r + 6'd1;
    end else if (cmd.cl_step) begin
      rem_r <= 24'(mod_step({rem_r[3:0], dvd_r[31:28]}));
      dvd_r <= {dvd_r[43:0], 4'd0};
      cnt_r <= cnt_r + 6'd1;
    end
    if (cmd.arr_ld) begin
      arr_r <= t_sum[32] ? TIME_MAX : t_sum[31:0];
    end
    if (cmd.m_inc) begin
      m_r <= m_r + IW'(1);
    end
    if (cmd.e_ld) begin
      e_r <= intv_q[63:32];
    end
    if (cmd.mul_ld) begin
      prod_r <= 56'(sp_r) * 56'(e_r - t_r);
    end
    if (cmd.cov_ld) begin
      dist_r <= (cov >= {8'd0, dist_r}) ? 32'd0 : 32'(dist_r - cov[31:0]);
      t_r    <= e_r;
    end
    if (cmd.res_ld) begin
      out_time_r <= time_r;
      out_sat_r  <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= 4'd1;
      first_r     <= '0;
      prev_r      <= '0;
      time_r      <= '0;
      pos_r       <= '0;
      active_r    <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (cmd.tour_start) begin
        first_r  <= CW'(row_r);
        prev_r   <= CW'(row_r);
        time_r   <= '0;
        pos_r    <= '0;
        sat_r    <= 1'b0;
        active_r <= 1'b1;
      end
      if (cmd.arr_ld && (q_ovf || t_sum[32])) begin
        sat_r <= 1'b1;
      end
      if (cmd.commit) begin
        time_r <= arr_r;
        pos_r  <= m_r;
      end
      if (cmd.prev_upd) begin
        prev_r <= CW'(row_r);
      end
      if (cmd.res_ld) begin
        active_r    <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.req         = req_r;
    sts.last        = last_r;
    sts.dist_ok     = (int'(row_r) < MAX_CITIES) && (int'(col_r) < MAX_CITIES);
    sts.speed_ok    = (int'(row_r) < MAX_INTERVALS) && (int'(col_r) < MAX_CLUSTERS);
    sts.intv_ok     = int'(row_r) < MAX_INTERVALS;
    sts.row_ok      = int'(row_r) < MAX_CITIES;
    sts.tour_active = active_r;
    sts.srch_hit    = (t_r >= intv_q[31:0]) && (t_r < intv_q[63:32]);
    sts.srch_end    = int'(i_r) + 1 >= int'(n_used);
    sts.div_done    = int'(cnt_r) == DIV_STEPS;
    sts.cl_done     = int'(cnt_r) == CL_STEPS;
    sts.arr_gt_end  = arr_r > intv_q[63:32];
    sts.end_gt_t    = intv_q[63:32] > t_r;
    sts.m_last      = int'(m_r) + 1 >= int'(n_used);
    sts.out_busy    = out_valid_r && !out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_tour_time = out_time_r;
  assign out_saturated = out_sat_r;

endmodule

// ===== rtl/tdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdt_ctrl
// Sequencer for table loads, leg evaluation, interval walk and result.
// ----------------------------------------------------------------------------
module tdt_ctrl import tdt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tdt_sts_t sts,
  output tdt_cmd_t cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DECODE   = 5'd1;
  localparam logic [4:0] S_CL_DIV   = 5'd2;
  localparam logic [4:0] S_CL_WR    = 5'd3;
  localparam logic [4:0] S_LEG_RD   = 5'd4;
  localparam logic [4:0] S_LEG_LD   = 5'd5;
  localparam logic [4:0] S_SRCH_RD  = 5'd6;
  localparam logic [4:0] S_SRCH_CHK = 5'd7;
  localparam logic [4:0] S_DIV_ST   = 5'd8;
  localparam logic [4:0] S_DIV_RUN  = 5'd9;
  localparam logic [4:0] S_ARR      = 5'd10;
  localparam logic [4:0] S_END_RD   = 5'd11;
  localparam logic [4:0] S_END_CHK  = 5'd12;
  localparam logic [4:0] S_MUL      = 5'd13;
  localparam logic [4:0] S_COV      = 5'd14;
  localparam logic [4:0] S_COMMIT   = 5'd15;
  localparam logic [4:0] S_OUT      = 5'd16;

  logic [4:0] state_r, state_nxt;
  logic       close_r, close_nxt;
  logic       loop_r, loop_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt     = state_r;
    close_nxt     = close_r;
    loop_nxt      = loop_r;
    cmd           = '0;
    cmd.leg_close = close_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        unique case (sts.req)
          REQ_DIST:  cmd.wr_dist  = sts.dist_ok;
          REQ_CLUS: begin
            if (sts.dist_ok) begin
              cmd.div_start_cl = 1'b1;
              state_nxt        = S_CL_DIV;
            end
          end
          REQ_SPEED: cmd.wr_speed = sts.speed_ok;
          REQ_INTV:  cmd.wr_intv  = sts.intv_ok;
          REQ_VISIT: begin
            if (sts.row_ok) begin
              if (!sts.tour_active) begin
                cmd.tour_start = 1'b1;
                if (sts.last) begin
                  close_nxt = 1'b1;
                  state_nxt = S_LEG_RD;
                end
              end else begin
                close_nxt = 1'b0;
                state_nxt = S_LEG_RD;
              end
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_CL_DIV: begin
        if (sts.cl_done) begin
          state_nxt = S_CL_WR;
        end else begin
          cmd.cl_step = 1'b1;
        end
      end
      S_CL_WR: begin
        cmd.wr_clus = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_LEG_RD: state_nxt = S_LEG_LD;
      S_LEG_LD: begin
        cmd.leg_ld = 1'b1;
        loop_nxt   = 1'b0;
        state_nxt  = S_SRCH_RD;
      end
      S_SRCH_RD: state_nxt = S_SRCH_CHK;
      S_SRCH_CHK: begin
        if (sts.srch_hit) begin
          cmd.sp_ld = 1'b1;
          state_nxt = S_DIV_ST;
        end else if (sts.srch_end) begin
          cmd.sp_min = 1'b1;
          state_nxt  = S_DIV_ST;
        end else begin
          cmd.srch_inc = 1'b1;
          state_nxt    = S_SRCH_RD;
        end
      end
      S_DIV_ST: begin
        cmd.div_start_leg = 1'b1;
        state_nxt         = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (sts.div_done) begin
          state_nxt = S_ARR;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_ARR: begin
        cmd.arr_ld = 1'b1;
        if (!loop_r) begin
          state_nxt = S_END_RD;
        end else if (sts.m_last) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.m_inc = 1'b1;
          state_nxt = S_END_RD;
        end
      end
      S_END_RD: begin
        cmd.intv_sel_m = 1'b1;
        state_nxt      = S_END_CHK;
      end
      S_END_CHK: begin
        if (!sts.arr_gt_end) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.e_ld = 1'b1;
          loop_nxt = 1'b1;
          state_nxt = sts.end_gt_t ? S_MUL : S_SRCH_RD;
        end
      end
      S_MUL: begin
        cmd.mul_ld = 1'b1;
        state_nxt  = S_COV;
      end
      S_COV: begin
        cmd.cov_ld = 1'b1;
        state_nxt  = S_SRCH_RD;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        if (close_r) begin
          state_nxt = S_OUT;
        end else begin
          cmd.prev_upd = 1'b1;
          if (sts.last) begin
            close_nxt = 1'b1;
            state_nxt = S_LEG_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      close_r <= 1'b0;
      loop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      close_r <= close_nxt;
      loop_r  <= loop_nxt;
    end
  end

endmodule

// ===== rtl/time_dependent_tour_time_core.sv =====
// ----------------------------------------------------------------------------
// time_dependent_tour_time_core
// Time-dependent tour time: table loads, then visits; one result per tour.
// ----------------------------------------------------------------------------
// channel  dir  handshake           payload
// in       in   in_valid/in_ready   req_type row_index col_index load_value
//                                   load_value_hi last_city
// out      out  out_valid/out_ready tour_time saturated
// cfg      in   cfg_we              cfg_wdata (interval_count)
//
// Loads are written from the decode state; a cluster load first runs 8
// nibble remainder steps. A leg searches the intervals and runs the 48-step
// radix-2 divider, which dominates; both repeat per boundary crossed.
// A closing visit runs its leg, if any, and the leg back to the start.
// Synchronous active-low reset; no clearing pass. A pending result holds
// while a new item is accepted; a finished tour waits for the output slot.
// ----------------------------------------------------------------------------
module time_dependent_tour_time_core import tdt_pkg::*; #(
  parameter int MAX_CITIES    = DEF_MAX_CITIES,
  parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
  parameter int MAX_CLUSTERS  = DEF_MAX_CLUSTERS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [5:0]  in_row_index,
  input  logic [5:0]  in_col_index,
  input  logic [31:0] in_load_value,
  input  logic [31:0] in_load_value_hi,
  input  logic        in_last_city,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_tour_time,
  output logic        out_saturated
);

  tdt_cmd_t cmd;
  tdt_sts_t sts;

  tdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdt_datapath #(
    .MAX_CITIES    (MAX_CITIES),
    .MAX_INTERVALS (MAX_INTERVALS),
    .MAX_CLUSTERS  (MAX_CLUSTERS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req_type),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_load_value    (in_load_value),
    .in_load_value_hi (in_load_value_hi),
    .in_last_city     (in_last_city),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tour_time    (out_tour_time),
    .out_saturated    (out_saturated)
  );

endmodule

// ===== rtl/tdt_checker.sv =====
// ----------------------------------------------------------------------------
// tdt_checker
// Port-level checks for the tour time core.
// ----------------------------------------------------------------------------
module tdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_tour_time,
  input logic        out_saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tour_time) && $stable(out_saturated))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an accepted item");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

endmodule

bind time_dependent_tour_time_core tdt_checker u_tdt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_tour_time (out_tour_time),
  .out_saturated (out_saturated)
);

// ===== test/time_dependent_tour_time_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_dependent_tour_time_core_test
// Loads distance, cluster, speed and interval tables, then runs tours of
// visits through the core under random valid/ready idling. A scoreboard
// predicts each tour time and saturation flag and checks every result in
// order. The interval count is changed between phases, extremes included.
// ----------------------------------------------------------------------------
module time_dependent_tour_time_core_test;
  import tdt_pkg::*;

  localparam int          NCITY      = 6;
  localparam logic [2:0]  REQ_BAD_LO = 3'd5;
  localparam logic [2:0]  REQ_BAD_MID = 3'd6;
  localparam logic [2:0]  REQ_TOP    = 3'd7;
  localparam logic [31:0] SPAN       = 32'h0010_0000;
  localparam int          WD_LIMIT   = 20000;
  localparam int          SETTLE     = 2000;
  localparam int          PHASE_ITEMS = 48;

  typedef struct {
    logic [31:0] tour_time;
    logic        saturated;
  } tour_res_t;

  class tour_scoreboard;
    logic [31:0] dist_tab [64*64];
    logic [1:0]  clus_tab [64*64];
    logic [23:0] speed_tab [32];
    logic [31:0] istart [8];
    logic [31:0] iend [8];
    logic [31:0] now;
    int          ipos;
    int          first_c;
    int          prev_c;
    bit          active;
    bit          sat;
    int          icount = 1;
    tour_res_t   expected_tours[$];
    int          errors;

    function int used();
      if (icount == 0) return 1;
      if (icount > 8) return 8;
      return icount;
    endfunction

    function logic [31:0] speed_at(logic [1:0] cl, logic [31:0] t);
      logic [23:0] s;
      for (int i = 0; i < used(); i++) begin
        if (t >= istart[i] && t < iend[i]) begin
          s = speed_tab[i*4 + cl];
          return (s == 0) ? 32'(MIN_SPEED) : 32'(s);
        end
      end
      return 32'(MIN_SPEED);
    endfunction

    function logic [31:0] arrive(logic [31:0] t, logic [31:0] d, logic [31:0] sp);
      longint unsigned q;
      longint unsigned s;
      q = (64'(d) << 16) / 64'(sp);
      if (q > 64'(TIME_MAX)) begin
        q = 64'(TIME_MAX);
        sat = 1;
      end
      s = 64'(t) + q;
      if (s > 64'(TIME_MAX)) begin
        s = 64'(TIME_MAX);
        sat = 1;
      end
      return s[31:0];
    endfunction

    function void leg(int from, int to);
      logic [1:0]  cl;
      logic [31:0] d, t, sp, arr, e;
      longint unsigned cov;
      int n, m;
      cl = clus_tab[from*64 + to];
      d = dist_tab[from*64 + to];
      t = now;
      n = used();
      m = ipos;
      if (m >= n) m = n - 1;
      sp = speed_at(cl, t);
      arr = arrive(t, d, sp);
      while (arr > iend[m]) begin
        e = iend[m];
        if (e > t) begin
          cov = (64'(sp) * 64'(e - t)) >> 16;
          d = (cov >= 64'(d)) ? 32'd0 : d - cov[31:0];
          t = e;
        end
        sp = speed_at(cl, t);
        arr = arrive(t, d, sp);
        if (m + 1 < n) m++;
        else break;
      end
      now = arr;
      ipos = m;
    endfunction

    function void note(logic [2:0] req, logic [5:0] row, logic [5:0] col,
                       logic [31:0] v, logic [31:0] vh, logic last);
      tour_res_t r;
      case (req)
        REQ_DIST: dist_tab[row*64 + col] = v;
        REQ_CLUS: clus_tab[row*64 + col] = v[1:0];
        REQ_SPEED: if (row < 8 && col < 4) speed_tab[row*4 + col] = v[23:0];
        REQ_INTV: if (row < 8) begin
          istart[row] = v;
          iend[row] = vh;
        end
        REQ_VISIT: begin
          if (!active) begin
            active = 1;
            first_c = row;
            prev_c = row;
            now = 0;
            ipos = 0;
            sat = 0;
          end else begin
            leg(prev_c, row);
            prev_c = row;
          end
          if (last) begin
            leg(prev_c, first_c);
            active = 0;
            r.tour_time = now;
            r.saturated = sat;
            expected_tours.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void check(logic [31:0] tt, logic s);
      tour_res_t r;
      if (expected_tours.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result tour_time=%h saturated=%b", tt, s);
        return;
      end
      r = expected_tours.pop_front();
      if (tt !== r.tour_time || s !== r.saturated) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected tour_time=%h saturated=%b, got %h %b",
                   r.tour_time, r.saturated, tt, s);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_req_type = '0;
  logic [5:0]  in_row_index = '0;
  logic [5:0]  in_col_index = '0;
  logic [31:0] in_load_value = '0;
  logic [31:0] in_load_value_hi = '0;
  logic        in_last_city = 0;
  logic        cfg_we = 0;
  logic [3:0]  cfg_wdata = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] out_tour_time;
  logic        out_saturated;

  tour_scoreboard sb = new();
  bit          calm = 0;
  int          idle_cycles = 0;
  int          hold = 0;
  logic [5:0]  cities [NCITY];

  time_dependent_tour_time_core dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note(in_req_type, in_row_index, in_col_index, in_load_value,
              in_load_value_hi, in_last_city);
    if (rst_n && out_valid && out_ready) sb.check(out_tour_time, out_saturated);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (calm) out_ready <= 1;
    else if (hold > 0) begin
      hold--;
      out_ready <= 0;
    end else if ($urandom_range(0, 9) < 2) begin
      hold = $urandom_range(0, 4);
      out_ready <= 0;
    end else out_ready <= 1;
  end

  task automatic send(logic [2:0] req, logic [5:0] row, logic [5:0] col,
                      logic [31:0] v, logic [31:0] vh, logic last);
    if (!calm && $urandom_range(0, 9) < 3) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= req;
    in_row_index <= row;
    in_col_index <= col;
    in_load_value <= v;
    in_load_value_hi <= vh;
    in_last_city <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic set_intervals(logic [3:0] n);
    in_valid <= 0;
    while (sb.expected_tours.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 0;
    sb.icount = n;
  endtask

  function automatic logic [31:0] rand_dist();
    if ($urandom_range(0, 19) == 0) return $urandom;
    return $urandom_range(32'h1000, 32'h20_0000);
  endfunction

  function automatic logic [31:0] rand_speed();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32'h00FF_FFFF;
      default: return $urandom_range(32'h4000, 32'h4_0000);
    endcase
  endfunction

  task automatic load_interval(int i);
    logic [31:0] s;
    if ($urandom_range(0, 9) == 0)
      send(REQ_INTV, 6'(i), 6'($urandom), $urandom, $urandom, 1'b0);
    else begin
      s = i * SPAN + ((i == 3) ? SPAN / 2 : 0);
      send(REQ_INTV, 6'(i), 6'($urandom), s, (i + 1) * SPAN, 1'($urandom));
    end
  endtask

  task automatic tour();
    int len;
    len = $urandom_range(1, 5);
    for (int k = 0; k < len; k++)
      send(REQ_VISIT, cities[$urandom_range(0, NCITY - 1)], 6'($urandom), $urandom,
           $urandom, k == len - 1);
  endtask

  task automatic random_item();
    int kind;
    logic [2:0] r;
    kind = $urandom_range(0, 99);
    if (kind < 60) tour();
    else if (kind < 70)
      send(REQ_DIST, cities[$urandom_range(0, NCITY - 1)],
           cities[$urandom_range(0, NCITY - 1)], rand_dist(), $urandom, 1'($urandom));
    else if (kind < 75)
      send(REQ_CLUS, cities[$urandom_range(0, NCITY - 1)],
           cities[$urandom_range(0, NCITY - 1)], $urandom, $urandom, 1'($urandom));
    else if (kind < 83)
      send(REQ_SPEED, 6'($urandom_range(0, 7)), 6'($urandom_range(0, 3)), rand_speed(),
           $urandom, 1'($urandom));
    else if (kind < 88) load_interval($urandom_range(0, 7));
    else begin
      do r = 3'($urandom); while (r == REQ_VISIT);
      if (r == REQ_DIST || r == REQ_CLUS)
        r = 3'($urandom_range(int'(REQ_BAD_LO), int'(REQ_TOP)));
      send(r, 6'($urandom), 6'($urandom), $urandom, $urandom, 1'($urandom));
    end
  endtask

  initial begin
    logic [3:0] counts [5];
    counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3};
    cities[0] = 0;
    cities[1] = 63;
    cities[2] = 21;
    cities[3] = 42;
    cities[4] = 6'($urandom_range(1, 62));
    cities[5] = 6'($urandom_range(1, 62));
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= 4'd4;
    @(posedge clk);
    cfg_we <= 0;
    sb.icount = 4;

    for (int a = 0; a < NCITY; a++)
      for (int b = 0; b < NCITY; b++) begin
        send(REQ_DIST, cities[a], cities[b], rand_dist(), $urandom, 1'($urandom));
        send(REQ_CLUS, cities[a], cities[b], $urandom, $urandom, 1'($urandom));
      end
    for (int i = 0; i < 8; i++)
      for (int c = 0; c < 4; c++)
        send(REQ_SPEED, 6'(i), 6'(c), $urandom_range(32'h4000, 32'h4_0000), $urandom,
             1'b0);
    for (int i = 0; i < 8; i++)
      send(REQ_INTV, 6'(i), 6'($urandom), i * SPAN + ((i == 3) ? SPAN / 2 : 0),
           (i + 1) * SPAN, 1'b0);

    send(REQ_VISIT, 63, 0, 0, 0, 1);
    send(REQ_VISIT, 0, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send(REQ_VISIT, 63, 0, 0, 0, 0);
    send(REQ_VISIT, 21, 0, 0, 0, 1);
    send(REQ_DIST, 0, 63, 32'hFFFF_FFFF, 0, 0);
    send(REQ_CLUS, 0, 63, 32'hFFFF_FFFF, 0, 0);
    for (int c = 0; c < 4; c++) send(REQ_SPEED, 0, 6'(c), 0, 0, 0);
    send(REQ_VISIT, 0, 0, 0, 0, 0);
    send(REQ_VISIT, 63, 0, 0, 0, 1);
    send(REQ_SPEED, 8, 0, 32'h1234, 0, 0);
    send(REQ_SPEED, 0, 4, 32'h1234, 0, 0);
    send(REQ_SPEED, 1, 63, 32'hFFFF_FFFF, 0, 0);
    send(REQ_INTV, 63, 0, 0, 0, 0);
    send(REQ_BAD_LO, 63, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send(REQ_BAD_MID, 0, 0, 0, 0, 0);
    send(REQ_TOP, 63, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    for (int c = 0; c < 4; c++) send(REQ_SPEED, 0, 6'(c), rand_speed(), 0, 0);
    send(REQ_DIST, 0, 63, rand_dist(), 0, 0);

    for (int p = 0; p < 5; p++) begin
      set_intervals(counts[p]);
      if (p == 4) calm = 1;
      for (int k = 0; k < PHASE_ITEMS; k++) random_item();
    end

    in_valid <= 0;
    while (sb.expected_tours.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
